// File: rtl/core/pwmfdm_pkg.sv
package pwmfdm_pkg;

    localparam int FREQ_BITS   = 32;
    localparam int DUTY_BITS   = 7;
    localparam int EDGE_BITS   = 24;
    localparam int PERIOD_BITS = 24;
    localparam int TS_BITS     = 27;
    localparam int CHAN_BITS   = 3;
    localparam int LEVEL_BASE  = 16;
    localparam int CNT_BITS    = $clog2(FREQ_BITS + 1);
    localparam int IN_BITS     = 112;
    localparam int OUT_BITS    = 64;

    localparam logic [DUTY_BITS-1:0] DUTY_FULL    = 7'd100;
    localparam logic [FREQ_BITS-1:0] CLK_HZ_RESET = 32'd100000000;

    typedef enum logic [1:0] {
        CFG_MODE     = 2'd0,
        CFG_CAP_CLK  = 2'd1,
        CFG_TB_CLK   = 2'd2,
        CFG_CHANNEL  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]             pad;
        logic [TS_BITS-1:0]     time_stamp;
        logic [EDGE_BITS-1:0]   edge_total;
        logic [PERIOD_BITS-1:0] period_ticks;
        logic [31:0]            capture_word;
        logic                   data_lost;
        logic                   timeout_hit;
        logic                   new_data;
    } in_data_t;

    typedef struct packed {
        logic                 ready_res;
        logic [EDGE_BITS-1:0] edges_seen;
        logic [DUTY_BITS-1:0] duty_percent;
        logic [FREQ_BITS-1:0] frequency_hz;
    } out_data_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic load_duty;
        logic store_duty;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic go;
        logic out_busy;
    } dp_stat_t;

endpackage

// File: rtl/core/pwmfdm_ctrl.sv
module pwmfdm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pwmfdm_pkg::dp_stat_t  stat,
    output pwmfdm_pkg::ctrl_cmd_t cmd
);
    import pwmfdm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_CHECK     = 7'b0000010,
        ST_FREQ      = 7'b0000100,
        ST_DUTY_LOAD = 7'b0001000,
        ST_DUTY      = 7'b0010000,
        ST_DUTY_END  = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.go)
                begin
                    cnt_next   = CNT_BITS'(FREQ_BITS);
                    state_next = ST_FREQ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREQ:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    state_next = ST_DUTY_LOAD;
                end
            end
            ST_DUTY_LOAD:
            begin
                cmd.load_duty = 1'b1;
                cnt_next      = CNT_BITS'(DUTY_BITS);
                state_next    = ST_DUTY;
            end
            ST_DUTY:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    state_next = ST_DUTY_END;
                end
            end
            ST_DUTY_END:
            begin
                cmd.store_duty = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_step_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREQ || state_reg == ST_DUTY) |-> cnt_reg != '0)
        else $error("divider step counter ran out inside a division");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_CHECK)
        else $error("accepted transaction did not move to the check state");

endmodule

// File: rtl/core/pwmfdm_dp.sv
module pwmfdm_dp #(
    parameter int STAMP_BITS = 27
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  pwmfdm_pkg::in_data_t  in_data,
    input  logic                  in_kind,
    input  pwmfdm_pkg::ctrl_cmd_t cmd,
    output pwmfdm_pkg::dp_stat_t  stat,
    output pwmfdm_pkg::out_data_t out_data,
    output logic                  out_valid,
    input  logic                  out_ready
);
    import pwmfdm_pkg::*;

    localparam int PW = (STAMP_BITS > PERIOD_BITS) ? STAMP_BITS : PERIOD_BITS;

    logic                  mode_reg, mode_next;
    logic [FREQ_BITS-1:0]  cap_clk_reg, cap_clk_next;
    logic [FREQ_BITS-1:0]  tb_clk_reg, tb_clk_next;
    logic [CHAN_BITS-1:0]  chan_reg, chan_next;

    logic [FREQ_BITS-1:0]  freq_reg, freq_next;
    logic [DUTY_BITS-1:0]  duty_reg, duty_next;
    logic [EDGE_BITS-1:0]  edge_reg, edge_next;
    logic                  ready_reg, ready_next;
    logic [1:0]            hist_reg, hist_next;
    logic [STAMP_BITS-1:0] rise_reg, rise_next;
    logic [STAMP_BITS-1:0] fall_reg, fall_next;

    logic                  go_reg, go_next;
    logic [PW-1:0]         dvsr_reg, dvsr_next;
    logic [31:0]           pulse_reg, pulse_next;
    logic [PW+6:0]         prod_reg;
    logic                  sat_reg;
    logic [FREQ_BITS-1:0]  work_reg, work_next;
    logic [PW-1:0]         rem_reg, rem_next;

    out_data_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [STAMP_BITS-1:0] ts_s;
    logic [STAMP_BITS-1:0] ev_period;
    logic [STAMP_BITS-1:0] ev_pulse;
    logic [7:0]            level_bits;
    logic                  level;
    logic [1:0]            hist_eff;
    logic [PW:0]           rem_shift;
    logic                  rem_ge;

    assign ts_s       = STAMP_BITS'(in_data.time_stamp);
    assign ev_period  = ts_s - rise_reg;
    assign ev_pulse   = fall_reg - rise_reg;
    assign level_bits = in_data.capture_word[LEVEL_BASE +: 8];
    assign level      = level_bits[chan_reg];
    assign hist_eff   = in_data.data_lost ? 2'd0 : hist_reg;
    assign rem_shift  = {rem_reg, work_reg[FREQ_BITS-1]};
    assign rem_ge     = rem_shift >= {1'b0, dvsr_reg};

    always_comb
    begin
        mode_next      = mode_reg;
        cap_clk_next   = cap_clk_reg;
        tb_clk_next    = tb_clk_reg;
        chan_next      = chan_reg;
        freq_next      = freq_reg;
        duty_next      = duty_reg;
        edge_next      = edge_reg;
        ready_next     = ready_reg;
        hist_next      = hist_reg;
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        go_next        = go_reg;
        dvsr_next      = dvsr_reg;
        pulse_next     = pulse_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_MODE:    mode_next    = cfg_data[0];
                CFG_CAP_CLK: cap_clk_next = cfg_data;
                CFG_TB_CLK:  tb_clk_next  = cfg_data;
                CFG_CHANNEL: chan_next    = cfg_data[CHAN_BITS-1:0];
                default:     mode_next    = mode_reg;
            endcase
        end

        if (cmd.accept)
        begin
            go_next = 1'b0;
            if (in_kind)
            begin
                freq_next = '0;
                duty_next = '0;
                edge_next = '0;
            end
            else
            begin
                if (in_data.timeout_hit && !mode_reg)
                begin
                    freq_next  = '0;
                    duty_next  = '0;
                    edge_next  = '0;
                    ready_next = 1'b1;
                end
                if (in_data.new_data)
                begin
                    edge_next = in_data.edge_total;
                    if (!mode_reg)
                    begin
                        dvsr_next  = PW'(in_data.period_ticks);
                        pulse_next = in_data.capture_word;
                        work_next  = cap_clk_reg;
                        rem_next   = '0;
                        ready_next = 1'b1;
                        if (in_data.period_ticks == '0)
                        begin
                            freq_next = '0;
                            duty_next = '0;
                        end
                        else
                        begin
                            go_next = 1'b1;
                        end
                    end
                    else
                    begin
                        hist_next = hist_eff;
                        if (hist_eff == 2'd2)
                        begin
                            dvsr_next  = PW'(ev_period);
                            pulse_next = 32'(ev_pulse);
                            work_next  = tb_clk_reg;
                            rem_next   = '0;
                            rise_next  = ts_s;
                            hist_next  = 2'd1;
                            ready_next = 1'b1;
                            if (ev_period == '0)
                            begin
                                freq_next = '0;
                                duty_next = '0;
                            end
                            else
                            begin
                                go_next = 1'b1;
                            end
                        end
                        else if (level && hist_eff == 2'd0)
                        begin
                            rise_next = ts_s;
                            hist_next = 2'd1;
                        end
                        else if (!level && hist_eff == 2'd1)
                        begin
                            fall_next = ts_s;
                            hist_next = 2'd2;
                        end
                    end
                end
            end
        end

        if (cmd.step)
        begin
            rem_next  = rem_ge ? PW'(rem_shift - {1'b0, dvsr_reg}) : rem_shift[PW-1:0];
            work_next = {work_reg[FREQ_BITS-2:0], rem_ge};
        end

        if (cmd.load_duty)
        begin
            freq_next = work_reg;
            work_next = {prod_reg[DUTY_BITS-1:0], {(FREQ_BITS-DUTY_BITS){1'b0}}};
            rem_next  = prod_reg[PW+6:DUTY_BITS];
        end

        if (cmd.store_duty)
        begin
            duty_next = sat_reg ? DUTY_FULL : work_reg[DUTY_BITS-1:0];
        end

        if (cmd.emit)
        begin
            out_next.frequency_hz = freq_reg;
            out_next.duty_percent = duty_reg;
            out_next.edges_seen   = edge_reg;
            out_next.ready_res    = ready_reg;
            out_valid_next        = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            cap_clk_reg   <= CLK_HZ_RESET;
            tb_clk_reg    <= CLK_HZ_RESET;
            chan_reg      <= '0;
            freq_reg      <= '0;
            duty_reg      <= '0;
            edge_reg      <= '0;
            ready_reg     <= 1'b0;
            hist_reg      <= 2'd0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            cap_clk_reg   <= cap_clk_next;
            tb_clk_reg    <= tb_clk_next;
            chan_reg      <= chan_next;
            freq_reg      <= freq_next;
            duty_reg      <= duty_next;
            edge_reg      <= edge_next;
            ready_reg     <= ready_next;
            hist_reg      <= hist_next;
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The product is only used when the pulse is shorter than the period.
    always_ff @(posedge clk)
    begin
        dvsr_reg  <= dvsr_next;
        pulse_reg <= pulse_next;
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        out_reg   <= out_next;
        prod_reg  <= (PW+7)'(pulse_reg[PW-1:0]) * (PW+7)'(DUTY_FULL);
        sat_reg   <= pulse_reg >= 32'(dvsr_reg);
    end

    assign stat.go       = go_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_data      = out_reg;
    assign out_valid     = out_valid_reg;

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_FULL)
        else $error("stored duty exceeds full scale");

    a_hist_range: assert property (@(posedge clk) disable iff (!rst_n)
        hist_reg != 2'd3)
        else $error("edge history count out of range");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("result register not valid after emit");

endmodule

// File: rtl/core/pwm_input_freq_duty_meter_core.sv
// Channel   Direction  Handshake                      Payload
// cfg       in         cfg_we                         cfg_index, cfg_data
// s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata, s_axis_tuser
// m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata
//
// An item that runs the divider passes the check, the 32 frequency steps of the serial
// divider, the duty load, 7 duty steps on the same divider and the duty store; any other
// item goes from the check straight to the result. The result is emitted once the result
// register is free, and only then is the input ready for the next item.
// Reset clears all measurements and the edge history and loads the register defaults.
// A stalled result register holds the finished item; the next item may still be accepted.
module pwm_input_freq_duty_meter_core #(
    parameter int STAMP_BITS = 27
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // new_data, timeout_hit, data_lost, capture_word[31:0], period_ticks[23:0],
    // edge_total[23:0], time_stamp[26:0], two zero bits
    input  logic [pwmfdm_pkg::IN_BITS-1:0] s_axis_tdata,
    // kind
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // frequency_hz[31:0], duty_percent[6:0], edges_seen[23:0], ready_res
    output logic [pwmfdm_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import pwmfdm_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    in_data_t  in_data;
    out_data_t out_data;

    assign in_data      = s_axis_tdata;
    assign m_axis_tdata = out_data;

    pwmfdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pwmfdm_dp #(
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .in_kind   (s_axis_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

endmodule
